/* sv/ppi_pkg.sv */
// Package for the path point interpolator.
// Holds operation and status codes, state encoding and the point record type.
// Depends on nothing.
package ppi_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_CLAMP_START = 3'd1,
    ST_CLAMP_END   = 3'd2,
    ST_EMPTY       = 3'd3,
    ST_FULL        = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_FIRST,
    S_RD_LAST,
    S_CHECK,
    S_SCAN,
    S_SCAN_CHK,
    S_RD_PAIR,
    S_DIVIDE,
    S_MUL,
    S_ADD,
    S_PUT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] st;
    logic [15:0] hd;
    logic [31:0] cv;
    logic [31:0] cr;
    logic [31:0] ca;
  } point_t;

  localparam int NumLanes = 7;

endpackage

/* sv/path_point_interpolator.sv */
// Path point interpolator top level: point memory, linear search, division and blend.
// Depends on ppi_pkg. Each result shows for one cycle on done; the receiver cannot stall.
// Append, clear and empty queries go straight to the result; other queries read the first and last
// points and clamp outside the tolerance, else scan linearly from index zero; interpolating
// queries then run a restoring divider and a blend. Busy holds new items off until the result
// has shown. Reset empties the table.
module path_point_interpolator #(
  parameter int MAX_POINTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [1:0]  operation,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [31:0] station,
  input  logic [15:0] heading,
  input  logic signed [31:0] curvature,
  input  logic signed [31:0] curvature_rate,
  input  logic signed [31:0] curvature_accel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [31:0] out_station,
  output logic [15:0] out_heading,
  output logic signed [31:0] out_curvature,
  output logic signed [31:0] out_curvature_rate,
  output logic signed [31:0] out_curvature_accel,
  output logic [9:0]  match_index,
  output logic [2:0]  status
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  ppi_pkg::point_t mem [MAX_POINTS];
  ppi_pkg::point_t rd_data;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;

  ppi_pkg::state_t state, state_next;
  logic [CW-1:0]   point_count;
  logic [15:0]     tolerance;
  logic [1:0]      op;
  logic [31:0]     qs;
  ppi_pkg::point_t in_pt;
  ppi_pkg::point_t p0;
  ppi_pkg::point_t p1;
  logic [CW-1:0]   idx;
  logic [AW-1:0]   res_idx;
  logic [2:0]      res_status;
  logic            res_interp;
  logic            far_end;
  logic [63:0]     rem;
  logic [32:0]     div_span;
  logic [31:0]     quot;
  logic [5:0]      step;
  logic signed [49:0] prod_hi [ppi_pkg::NumLanes];
  logic signed [49:0] prod_lo [ppi_pkg::NumLanes];
  logic signed [32:0] delta [ppi_pkg::NumLanes];
  logic signed [31:0] base [ppi_pkg::NumLanes];
  logic [31:0]     blended [ppi_pkg::NumLanes];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[point_count[AW-1:0]] <= in_pt;
    end
    rd_data <= mem[rd_addr];
  end

  assign wr_en = (state == ppi_pkg::S_RD_FIRST) && (op == ppi_pkg::OP_APPEND) &&
                 (point_count < CW'(MAX_POINTS));
  assign busy = (state != ppi_pkg::S_IDLE);
  assign cfg_ready = (state == ppi_pkg::S_IDLE) && !start;
  assign far_end = ({1'b0, qs} > {1'b0, rd_data.st} + 33'(tolerance));

  always_comb begin
    unique case (state)
      ppi_pkg::S_RD_FIRST: rd_addr = '0;
      ppi_pkg::S_RD_LAST:  rd_addr = AW'(point_count - CW'(1));
      ppi_pkg::S_SCAN:     rd_addr = idx[AW-1:0];
      ppi_pkg::S_SCAN_CHK: rd_addr = AW'(idx - CW'(1));
      default:             rd_addr = idx[AW-1:0];
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ppi_pkg::S_IDLE:     if (start) state_next = ppi_pkg::S_RD_FIRST;
      ppi_pkg::S_RD_FIRST: begin
        if (op == ppi_pkg::OP_QUERY && point_count != '0) begin
          state_next = ppi_pkg::S_RD_LAST;
        end else begin
          state_next = ppi_pkg::S_PUT;
        end
      end
      ppi_pkg::S_RD_LAST:  state_next = ppi_pkg::S_CHECK;
      ppi_pkg::S_CHECK: begin
        if (res_status != ppi_pkg::ST_OK || !res_interp || far_end) begin
          state_next = ppi_pkg::S_PUT;
        end else begin
          state_next = ppi_pkg::S_SCAN;
        end
      end
      ppi_pkg::S_SCAN:     state_next = ppi_pkg::S_SCAN_CHK;
      ppi_pkg::S_SCAN_CHK: begin
        if (rd_data.st > qs) begin
          state_next = (idx == '0) ? ppi_pkg::S_PUT : ppi_pkg::S_RD_PAIR;
        end else if (idx == point_count - CW'(1)) begin
          state_next = ppi_pkg::S_PUT;
        end else begin
          state_next = ppi_pkg::S_SCAN;
        end
      end
      ppi_pkg::S_RD_PAIR:  state_next = ppi_pkg::S_DIVIDE;
      ppi_pkg::S_DIVIDE:   if (step == 6'd32) state_next = ppi_pkg::S_MUL;
      ppi_pkg::S_MUL:      state_next = ppi_pkg::S_ADD;
      ppi_pkg::S_ADD:      state_next = ppi_pkg::S_DONE;
      ppi_pkg::S_PUT:      state_next = ppi_pkg::S_DONE;
      ppi_pkg::S_DONE:     state_next = ppi_pkg::S_IDLE;
      default:             state_next = ppi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    delta[0] = 33'(signed'(p1.x)) - 33'(signed'(p0.x));
    delta[1] = 33'(signed'(p1.y)) - 33'(signed'(p0.y));
    delta[2] = 33'(signed'(p1.z)) - 33'(signed'(p0.z));
    delta[3] = 33'(signed'(p1.cv)) - 33'(signed'(p0.cv));
    delta[4] = 33'(signed'(p1.cr)) - 33'(signed'(p0.cr));
    delta[5] = 33'(signed'(p1.ca)) - 33'(signed'(p0.ca));
    delta[6] = (p1.hd - p0.hd > 16'd32768) ?
               33'(signed'({1'b1, p1.hd - p0.hd})) : 33'({1'b0, p1.hd - p0.hd});
    base[0] = p0.x;
    base[1] = p0.y;
    base[2] = p0.z;
    base[3] = p0.cv;
    base[4] = p0.cr;
    base[5] = p0.ca;
    base[6] = 32'(p0.hd);
    for (int k = 0; k < ppi_pkg::NumLanes; k++) begin
      blended[k] = base[k] + 32'((prod_hi[k] + 50'sd32768 + (prod_lo[k] >>> 16)) >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ppi_pkg::S_IDLE;
      point_count <= '0;
      tolerance   <= 16'd655;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state_next == ppi_pkg::S_DONE);
      if (cfg_valid && cfg_ready) begin
        tolerance <= cfg_data;
      end
      if (state == ppi_pkg::S_RD_FIRST) begin
        if (op == ppi_pkg::OP_CLEAR) begin
          point_count <= '0;
        end else if (wr_en) begin
          point_count <= point_count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ppi_pkg::S_IDLE: begin
        op    <= operation;
        qs    <= station;
        in_pt <= '{x: pos_x, y: pos_y, z: pos_z, st: station, hd: heading,
                   cv: curvature, cr: curvature_rate, ca: curvature_accel};
        idx   <= '0;
      end
      ppi_pkg::S_RD_FIRST: begin
        res_idx    <= point_count[AW-1:0];
        res_interp <= 1'b0;
        if (op == ppi_pkg::OP_APPEND) begin
          res_status <= wr_en ? ppi_pkg::ST_OK : ppi_pkg::ST_FULL;
        end else if (op == ppi_pkg::OP_QUERY && point_count == '0) begin
          res_status <= ppi_pkg::ST_EMPTY;
        end else begin
          res_status <= ppi_pkg::ST_OK;
        end
      end
      ppi_pkg::S_RD_LAST: begin
        p0 <= rd_data;
        res_idx <= '0;
        if ({1'b0, qs} < {1'b0, rd_data.st} - 33'(tolerance) &&
            rd_data.st >= 32'(tolerance)) begin
          res_status <= ppi_pkg::ST_CLAMP_START;
        end
        res_interp <= 1'b1;
      end
      ppi_pkg::S_CHECK: begin
        if (res_status == ppi_pkg::ST_CLAMP_START) begin
          p1 <= p0;
        end else if (far_end) begin
          res_status <= ppi_pkg::ST_CLAMP_END;
          res_idx    <= AW'(point_count - CW'(1));
          p1         <= rd_data;
        end
      end
      ppi_pkg::S_SCAN_CHK: begin
        if (rd_data.st > qs) begin
          res_idx <= (idx == '0) ? '0 : AW'(idx - CW'(1));
          p1      <= rd_data;
        end else if (idx == point_count - CW'(1)) begin
          res_idx <= idx[AW-1:0];
          p1      <= rd_data;
        end
        idx <= idx + CW'(1);
      end
      ppi_pkg::S_RD_PAIR: begin
        p0       <= rd_data;
        res_interp <= 1'b1;
        rem      <= {32'(qs - rd_data.st), 32'd0};
        div_span <= {1'b0, p1.st - rd_data.st};
        step     <= '0;
        quot     <= '0;
      end
      ppi_pkg::S_DIVIDE: begin
        if (step != 6'd32) begin
          if (rem[63:31] >= div_span) begin
            rem  <= {rem[62:31] - div_span[31:0], rem[30:0], 1'b0};
            quot <= {quot[30:0], 1'b1};
          end else begin
            rem  <= {rem[62:0], 1'b0};
            quot <= {quot[30:0], 1'b0};
          end
          step <= step + 6'd1;
        end
      end
      ppi_pkg::S_MUL: begin
        for (int k = 0; k < ppi_pkg::NumLanes; k++) begin
          prod_hi[k] <= 50'(delta[k] * signed'({1'b0, quot[31:16]}));
          prod_lo[k] <= 50'(delta[k] * signed'({1'b0, quot[15:0]}));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ppi_pkg::S_ADD) begin
      out_x               <= blended[0];
      out_y               <= blended[1];
      out_z               <= blended[2];
      out_station         <= qs;
      out_heading         <= blended[6][15:0];
      out_curvature       <= blended[3];
      out_curvature_rate  <= blended[4];
      out_curvature_accel <= blended[5];
      match_index         <= 10'(res_idx);
      status              <= ppi_pkg::ST_OK;
    end else if (state == ppi_pkg::S_PUT) begin
      if (op == ppi_pkg::OP_QUERY && res_status != ppi_pkg::ST_EMPTY) begin
        out_x               <= p1.x;
        out_y               <= p1.y;
        out_z               <= p1.z;
        out_station         <= p1.st;
        out_heading         <= p1.hd;
        out_curvature       <= p1.cv;
        out_curvature_rate  <= p1.cr;
        out_curvature_accel <= p1.ca;
        match_index         <= 10'(res_idx);
      end else begin
        out_x               <= '0;
        out_y               <= '0;
        out_z               <= '0;
        out_station         <= '0;
        out_heading         <= '0;
        out_curvature       <= '0;
        out_curvature_rate  <= '0;
        out_curvature_accel <= '0;
        match_index         <= (op == ppi_pkg::OP_APPEND && res_status == ppi_pkg::ST_OK) ?
                               10'(res_idx) : 10'd0;
      end
      status <= res_status;
    end
  end

endmodule

/* sv/ppi_checker.sv */
// Port checker for the path point interpolator, bound to the top level.
// Depends on ppi_pkg for the status codes.
module ppi_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       cfg_ready,
  input logic [2:0] status
);

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted item did not raise busy");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without an item in work");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result shown for more than one beat");

  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (status <= ppi_pkg::ST_FULL)) else $error("status code out of range");

  a_cfg: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cfg_ready) else $error("configuration taken while busy");

endmodule

bind path_point_interpolator ppi_checker u_ppi_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .cfg_ready(cfg_ready), .status(status)
);

/* verif/path_point_interpolator_test.sv */
// Self-checking testbench for the path point interpolator: table operations,
// tolerance settings and interpolating queries are predicted and compared.
// Depends on ppi_pkg and path_point_interpolator.
module path_point_interpolator_test;

  typedef struct {
    logic [31:0] x, y, z, st;
    logic [15:0] hd;
    logic [31:0] cv, cr, ca;
    logic [9:0]  idx;
    ppi_pkg::status_t stat;
  } path_answer_t;

  class path_scoreboard;
    logic [31:0] px[1024], py[1024], pz[1024], pst[1024];
    logic [31:0] pcv[1024], pcr[1024], pca[1024];
    logic [15:0] phd[1024];
    int unsigned count;
    logic [15:0] tolerance;
    path_answer_t awaited[$];
    int errors;

    function new();
      count = 0;
      tolerance = 16'd655;
      errors = 0;
    endfunction

    function longint floor16(longint v);
      return v >>> 16;
    endfunction

    function longint blend(longint p0, longint d, longint t);
      longint a, b;
      a = d * (t >>> 16);
      b = d * (t & 64'hFFFF);
      return p0 + floor16(a + 32768 + floor16(b));
    endfunction

    function logic [31:0] mix(logic [31:0] a, logic [31:0] b, longint t);
      longint p0, p1;
      p0 = longint'($signed(a));
      p1 = longint'($signed(b));
      return 32'(blend(p0, p1 - p0, t));
    endfunction

    function path_answer_t take_point(int unsigned i, ppi_pkg::status_t s);
      path_answer_t r;
      r.x = px[i]; r.y = py[i]; r.z = pz[i]; r.st = pst[i]; r.hd = phd[i];
      r.cv = pcv[i]; r.cr = pcr[i]; r.ca = pca[i]; r.idx = 10'(i); r.stat = s;
      return r;
    endfunction

    function void note_beat(ppi_pkg::op_t op, logic [31:0] x, y, z, st, logic [15:0] hd,
                            logic [31:0] cv, cr, ca);
      path_answer_t r;
      int unsigned last, hit, i0;
      bit found;
      longint t, dh, s;
      logic [63:0] num, den;
      r = '{default: 0, stat: ppi_pkg::ST_OK};
      if (op == ppi_pkg::OP_CLEAR) begin
        count = 0;
      end else if (op == ppi_pkg::OP_APPEND) begin
        if (count >= 1024) begin
          r.stat = ppi_pkg::ST_FULL;
        end else begin
          px[count] = x; py[count] = y; pz[count] = z; pst[count] = st;
          phd[count] = hd; pcv[count] = cv; pcr[count] = cr; pca[count] = ca;
          r.idx = 10'(count);
          count++;
        end
      end else if (op == ppi_pkg::OP_QUERY) begin
        s = longint'(st);
        if (count == 0) begin
          r.stat = ppi_pkg::ST_EMPTY;
        end else begin
          last = count - 1;
          if (s < longint'(pst[0]) - longint'(tolerance)) begin
            r = take_point(0, ppi_pkg::ST_CLAMP_START);
          end else if (s > longint'(pst[last]) + longint'(tolerance)) begin
            r = take_point(last, ppi_pkg::ST_CLAMP_END);
          end else begin
            found = 0;
            hit = 0;
            for (int unsigned i = 0; i < count && !found; i++) begin
              if (pst[i] > st) begin
                hit = i;
                found = 1;
              end
            end
            if (!found) begin
              r = take_point(last, ppi_pkg::ST_OK);
            end else if (hit == 0) begin
              r = take_point(0, ppi_pkg::ST_OK);
            end else begin
              i0 = hit - 1;
              num = {st - pst[i0], 32'd0};
              den = {32'd0, pst[hit] - pst[i0]};
              t = longint'(num / den);
              dh = longint'(16'(phd[hit] - phd[i0]));
              if (dh > 32768) dh -= 65536;
              r.x = mix(px[i0], px[hit], t);
              r.y = mix(py[i0], py[hit], t);
              r.z = mix(pz[i0], pz[hit], t);
              r.st = st;
              r.hd = 16'(blend(longint'(phd[i0]), dh, t));
              r.cv = mix(pcv[i0], pcv[hit], t);
              r.cr = mix(pcr[i0], pcr[hit], t);
              r.ca = mix(pca[i0], pca[hit], t);
              r.idx = 10'(i0);
              r.stat = ppi_pkg::ST_OK;
            end
          end
        end
      end
      awaited.push_back(r);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      errors++;
    endfunction

    function void check_result(path_answer_t g);
      path_answer_t e;
      if (awaited.size() == 0) begin
        $display("mismatch: result with nothing outstanding");
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (g.x !== e.x) report("out_x", g.x, e.x);
      if (g.y !== e.y) report("out_y", g.y, e.y);
      if (g.z !== e.z) report("out_z", g.z, e.z);
      if (g.st !== e.st) report("out_station", g.st, e.st);
      if (g.hd !== e.hd) report("out_heading", g.hd, e.hd);
      if (g.cv !== e.cv) report("out_curvature", g.cv, e.cv);
      if (g.cr !== e.cr) report("out_curvature_rate", g.cr, e.cr);
      if (g.ca !== e.ca) report("out_curvature_accel", g.ca, e.ca);
      if (g.idx !== e.idx) report("match_index", 32'(g.idx), 32'(e.idx));
      if (g.stat !== e.stat) report("status", 32'(g.stat), 32'(e.stat));
    endfunction
  endclass

  logic clk = 0, rst = 1, start = 0, busy, done;
  logic [1:0] operation = 0;
  logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
  logic [31:0] station = 0;
  logic [15:0] heading = 0;
  logic signed [31:0] curvature = 0, curvature_rate = 0, curvature_accel = 0;
  logic cfg_valid = 0, cfg_ready;
  logic [15:0] cfg_data = 0;
  logic signed [31:0] out_x, out_y, out_z, out_curvature, out_curvature_rate;
  logic signed [31:0] out_curvature_accel;
  logic [31:0] out_station;
  logic [15:0] out_heading;
  logic [9:0] match_index;
  logic [2:0] status;
  longint cycles = 0;
  path_scoreboard board;
  logic [31:0] base_station;
  bit start_held = 0;

  path_point_interpolator DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 40_000_000) begin
      $display("** path_point_interpolator: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    path_answer_t g;
    if (!rst && done) begin
      g.x = out_x; g.y = out_y; g.z = out_z; g.st = out_station; g.hd = out_heading;
      g.cv = out_curvature; g.cr = out_curvature_rate; g.ca = out_curvature_accel;
      g.idx = match_index; g.stat = ppi_pkg::status_t'(status);
      board.check_result(g);
    end
  end

  function automatic int gap_length();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    return n;
  endfunction

  task automatic send_item(ppi_pkg::op_t op, logic [31:0] x, y, z, st, logic [15:0] hd,
                           logic [31:0] cv, cr, ca);
    int n;
    operation <= op; pos_x <= x; pos_y <= y; pos_z <= z; station <= st;
    heading <= hd; curvature <= cv; curvature_rate <= cr; curvature_accel <= ca;
    if (!start_held) start <= 1;
    start_held = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_beat(op, x, y, z, st, hd, cv, cr, ca);
    n = gap_length();
    if (n != 0) begin
      start <= 0;
      start_held = 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic append_point(logic [31:0] st);
    send_item(ppi_pkg::OP_APPEND, $urandom, $urandom, $urandom, st, 16'($urandom),
              $urandom, $urandom, $urandom);
  endtask

  task automatic query_at(logic [31:0] st);
    send_item(ppi_pkg::OP_QUERY, $urandom, $urandom, $urandom, st, 16'($urandom),
              $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    if (start_held) begin
      start <= 0;
      start_held = 0;
    end
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic set_tolerance(logic [15:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.tolerance = v;
    cfg_valid <= 0;
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    query_at(32'h0);
    send_item(ppi_pkg::OP_APPEND, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h0001_0000,
              16'hFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h0);
    send_item(ppi_pkg::OP_APPEND, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0003_0000,
              16'h7FFF, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    send_item(ppi_pkg::OP_APPEND, 32'h0, 32'h0, 32'h1, 32'hFFFF_FFFF, 16'h0, 32'h1, 32'h0,
              32'h80000000);
    query_at(32'h0);
    query_at(32'h0000_FFFF);
    query_at(32'h0001_0000);
    query_at(32'h0002_0000);
    query_at(32'h0002_FFFF);
    query_at(32'hFFFF_FFFF);
    send_item(ppi_pkg::OP_NONE, $urandom, $urandom, $urandom, $urandom, 16'($urandom),
              $urandom, $urandom, $urandom);
    send_item(ppi_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(ppi_pkg::OP_APPEND, 0, 0, 0, 32'h0010_0000, 16'h0000, 0, 0, 0);
    send_item(ppi_pkg::OP_APPEND, 0, 0, 0, 32'h0020_0000, 16'h8000, 0, 0, 0);
    send_item(ppi_pkg::OP_APPEND, 0, 0, 0, 32'h0010_0000, 16'h4000, 0, 0, 0);
    query_at(32'h0018_0000);
    query_at(32'h0020_0000);
    query_at(32'h0020_0100);
    query_at(32'h000F_FF00);

    // Fill the table completely to reach the full status and the top index.
    set_tolerance(16'd0);
    send_item(ppi_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 1024; i++) begin
      send_item(ppi_pkg::OP_APPEND, $urandom, $urandom, $urandom, 32'(i) << 12,
                16'($urandom), $urandom, $urandom, $urandom);
    end
    append_point(32'h0);
    query_at(32'h003F_F000);
    query_at(32'h0040_0000);
    query_at(32'h0000_0800);
    query_at(32'h003F_F800);
    set_tolerance(16'hFFFF);
    query_at(32'h0040_FFFF);
    query_at(32'h0041_0000);

    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 1) set_tolerance(16'($urandom));
      if (phase == 2) set_tolerance(16'd655);
      if (phase == 3) set_tolerance(16'd0);
      for (int seq = 0; seq < 15; seq++) begin
        int npts;
        send_item(ppi_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        npts = $urandom_range(1, 8);
        base_station = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20);
        for (int k = 0; k < npts; k++) begin
          if ($urandom_range(0, 15) == 0) append_point($urandom);
          else append_point(base_station);
          base_station = base_station + $urandom_range(0, 1 << 18);
        end
        repeat ($urandom_range(2, 8)) begin
          case ($urandom_range(0, 5))
            0: query_at($urandom);
            1: query_at(board.pst[0] - $urandom_range(0, 1 << 17));
            2: query_at(board.pst[board.count - 1] + $urandom_range(0, 1 << 17));
            3: send_item(ppi_pkg::op_t'($urandom_range(1, 3)), $urandom, $urandom, $urandom,
                         $urandom, 16'($urandom), $urandom, $urandom, $urandom);
            default: query_at(board.pst[0] + $urandom_range(0, base_station - board.pst[0]));
          endcase
        end
      end
    end
    drain();
    if (board.errors == 0 && board.awaited.size() == 0)
      $display("** path_point_interpolator: PASSED **");
    else
      $display("** path_point_interpolator: FAILED **");
    $finish;
  end
endmodule
